>>> sv/skhs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the string key hash set.
// No dependencies; imported by the top level.
package skhs_pkg;

	localparam int FRONT_W    = 64;
	localparam int BACK_W     = 56;
	localparam int KEY_W      = FRONT_W + BACK_W;
	localparam int KEY_OCTETS = KEY_W / 8;
	localparam int SLOT_NUM_W = 7;
	localparam int TOTAL_W    = 7;

	// hash = HASH_MULT * sum(octet * position); probe step adds j*j + PROBE_LIN*j
	localparam int HASH_MULT  = 19;
	localparam int PROBE_LIN  = 23;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]            action;
		logic [FRONT_W-1:0]    key_front;
		logic [BACK_W-1:0]     key_back;
		logic [SLOT_NUM_W-1:0] slot_number;
	} cmd_t;

	typedef struct packed {
		logic                  succeeded;
		logic [SLOT_NUM_W-1:0] slot_used;
		logic [TOTAL_W-1:0]    key_total;
		logic [FRONT_W-1:0]    found_front;
		logic [BACK_W-1:0]     found_back;
	} res_t;

endpackage

>>> sv/skhs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/string_key_hash_set_probing_top.sv
`timescale 1ns / 1ps
// Open-addressing string key set with quadratic probing.
// Depends on skhs_pkg and skhs_ram (slot key storage).
//
// Usage: a command word arrives on cmd (cmd_valid / cmd_stall) and yields
// exactly one result word on res (res_valid / res_stall). A word moves at an
// edge where valid is high and stall is low. One command is in work at a
// time; cmd_stall is high from acceptance until the result is placed in the
// output register.
// Clear and read go straight to the hand-off; read does its one slot RAM
// read at acceptance. Insert and delete step through hashing (one key octet
// per cycle), the hash multiply, the restoring mod reduction, probing (one
// slot RAM read and key compare per probe, up to PROBE_LIMIT probes) and
// commit, then hand off. A new command is taken only once the last one has
// handed off its result.
// A stalled receiver holds the output register; a new command is still
// taken and worked on, and waits to hand off until the register frees up.
// Reset empties the set (occupancy bits and key count) at once; no sweep.
module string_key_hash_set_probing_top
	import skhs_pkg::*;
#(
	parameter int SLOT_COUNT  = 101,
	parameter int PROBE_LIMIT = 20,
	parameter int KEY_BYTES   = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int SW      = $clog2(SLOT_COUNT);
	localparam int HB      = (KEY_BYTES < KEY_OCTETS) ? KEY_BYTES : KEY_OCTETS;
	localparam int SUM_MAX = 255 * HB * (HB + 1) / 2;
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int HW      = $clog2(SUM_MAX * HASH_MULT + 1);
	localparam int MK      = HW - SW;
	localparam int KW      = $clog2(MK + 1);
	localparam int JW      = $clog2(PROBE_LIMIT + 1);
	localparam int CW      = $clog2(SLOT_COUNT + 1);
	localparam int D0      = (PROBE_LIN + 1) % SLOT_COUNT;
	localparam int IW      = $clog2(KEY_OCTETS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_HASH   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_MOD    = 3'd3;
	localparam logic [2:0] ST_PROBE  = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]             state_q;
	logic [1:0]             act_q;
	logic [KEY_W-1:0]       key_q;
	logic [IW-1:0]          idx_q;
	logic                   alive_q;
	logic [SUM_W-1:0]       sum_q;
	logic [HW-1:0]          v_q;
	logic [KW-1:0]          k_q;
	logic [SW-1:0]          s_q;
	logic [SW-1:0]          d_q;
	logic [JW-1:0]          j_q;
	logic                   p_vld_s1;
	logic                   p_occ_s1;
	logic [SW-1:0]          p_slot_s1;
	logic                   dup_q;
	logic                   free_ok_q;
	logic [SW-1:0]          free_slot_q;
	logic                   hit_q;
	logic [SW-1:0]          hit_slot_q;
	logic                   pend_ok_q;
	logic [SW-1:0]          pend_slot_q;
	logic                   pend_rd_q;
	logic [CW-1:0]          count_q;
	logic [SLOT_COUNT-1:0]  occ_q;
	logic                   res_valid_q;
	res_t                   res_q;

	logic                   cmd_take;
	logic                   res_free;
	logic                   rd_in_range;
	logic [7:0]             octet;
	logic                   octet_live;
	logic [12:0]            term;
	logic [HW-1:0]          m_shift;
	logic [HW-1:0]          v_red;
	logic [SW:0]            s_sum;
	logic [SW:0]            d_sum;
	logic [SW-1:0]          s_nxt;
	logic [SW-1:0]          d_nxt;
	logic                   probe_issue;
	logic                   probe_hit;
	logic                   probe_free;
	logic                   ins_ok;
	logic                   ram_wr;
	logic                   ram_rd;
	logic [SW-1:0]          ram_rd_addr;
	logic [KEY_W-1:0]       ram_rd_data;

	assign cmd_stall   = (state_q != ST_IDLE);
	assign cmd_take    = cmd_valid && !cmd_stall;
	assign res_free    = !res_valid_q || !res_stall;
	assign res_valid   = res_valid_q;
	assign res         = res_q;
	assign rd_in_range = (int'(cmd.slot_number) < SLOT_COUNT);

	// hash datapath: one octet per cycle
	assign octet      = key_q[{idx_q, 3'b000} +: 8];
	assign octet_live = alive_q && (int'(idx_q) < HB) && (octet != 8'd0);
	assign term       = 13'(octet) * (13'(idx_q) + 13'd1);

	// restoring mod reduction, one shifted modulus per cycle
	assign m_shift = HW'(SLOT_COUNT) << k_q;
	assign v_red   = (v_q >= m_shift) ? (v_q - m_shift) : v_q;

	// quadratic probe walk: next slot adds 2j+24, kept mod SLOT_COUNT
	assign s_sum = {1'b0, s_q} + {1'b0, d_q};
	assign d_sum = {1'b0, d_q} + (SW + 1)'(2);
	assign s_nxt = (s_sum >= (SW + 1)'(SLOT_COUNT)) ?
		SW'(s_sum - (SW + 1)'(SLOT_COUNT)) : SW'(s_sum);
	assign d_nxt = (d_sum >= (SW + 1)'(SLOT_COUNT)) ?
		SW'(d_sum - (SW + 1)'(SLOT_COUNT)) : SW'(d_sum);

	assign probe_issue = (state_q == ST_PROBE) && (j_q != JW'(PROBE_LIMIT));
	assign probe_hit   = p_vld_s1 && p_occ_s1 && (ram_rd_data == key_q);
	assign probe_free  = p_vld_s1 && !p_occ_s1;
	assign ins_ok      = !dup_q && free_ok_q;

	assign ram_wr      = (state_q == ST_COMMIT) && (act_q == ACT_INSERT) && ins_ok;
	assign ram_rd      = probe_issue || (cmd_take && (cmd.action == ACT_READ) && rd_in_range);
	assign ram_rd_addr = probe_issue ? s_q : SW'(cmd.slot_number);

	skhs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(free_slot_q),
		.wr_data(key_q),
		.rd_en  (ram_rd),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			p_vld_s1    <= 1'b0;
			count_q     <= '0;
			occ_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			p_vld_s1 <= probe_issue;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						unique case (cmd.action)
							ACT_CLEAR: begin
								occ_q   <= '0;
								count_q <= '0;
								state_q <= ST_DONE;
							end
							ACT_READ: state_q <= ST_DONE;
							default:  state_q <= ST_HASH;
						endcase
					end
				end
				ST_HASH: begin
					if (idx_q == IW'(KEY_OCTETS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_MOD;
				ST_MOD: begin
					if (k_q == '0) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (!probe_issue && !p_vld_s1) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (act_q == ACT_INSERT) begin
						if (ins_ok) begin
							occ_q[free_slot_q] <= 1'b1;
							count_q            <= count_q + CW'(1);
						end
					end else if (hit_q) begin
						occ_q[hit_slot_q] <= 1'b0;
						count_q           <= count_q - CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (probe_issue) begin
			p_occ_s1  <= occ_q[s_q];
			p_slot_s1 <= s_q;
			s_q       <= s_nxt;
			d_q       <= d_nxt;
			j_q       <= j_q + JW'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				act_q   <= cmd.action;
				key_q   <= {cmd.key_back, cmd.key_front};
				idx_q   <= '0;
				alive_q <= 1'b1;
				sum_q   <= '0;
				pend_ok_q   <= (cmd.action == ACT_CLEAR) ||
					((cmd.action == ACT_READ) && rd_in_range &&
					occ_q[SW'(cmd.slot_number)]);
				pend_rd_q   <= (cmd.action == ACT_READ) && rd_in_range &&
					occ_q[SW'(cmd.slot_number)];
				pend_slot_q <= ((cmd.action == ACT_READ) && rd_in_range) ?
					SW'(cmd.slot_number) : '0;
			end
			ST_HASH: begin
				// clear every octet from the first zero on
				if (octet_live) begin
					sum_q <= sum_q + SUM_W'(term);
				end else begin
					key_q[{idx_q, 3'b000} +: 8] <= 8'd0;
					alive_q                     <= 1'b0;
				end
				idx_q <= idx_q + IW'(1);
			end
			ST_MUL: begin
				v_q <= HW'(sum_q * HASH_MULT);
				k_q <= KW'(MK);
			end
			ST_MOD: begin
				v_q <= v_red;
				k_q <= k_q - KW'(1);
				if (k_q == '0) begin
					s_q       <= SW'(v_red);
					d_q       <= SW'(D0);
					j_q       <= '0;
					dup_q     <= 1'b0;
					free_ok_q <= 1'b0;
					hit_q     <= 1'b0;
				end
			end
			ST_PROBE: begin
				if (probe_hit) begin
					dup_q <= 1'b1;
				end
				if (probe_free && !free_ok_q) begin
					free_ok_q   <= 1'b1;
					free_slot_q <= p_slot_s1;
				end
				// delete takes the first matching probe only
				if (probe_hit && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= p_slot_s1;
				end
			end
			ST_COMMIT: begin
				pend_rd_q <= 1'b0;
				if (act_q == ACT_INSERT) begin
					pend_ok_q   <= ins_ok;
					pend_slot_q <= ins_ok ? free_slot_q : '0;
				end else begin
					pend_ok_q   <= hit_q;
					pend_slot_q <= hit_q ? hit_slot_q : '0;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					res_q.succeeded   <= pend_ok_q;
					res_q.slot_used   <= SLOT_NUM_W'(pend_slot_q);
					res_q.key_total   <= TOTAL_W'(count_q);
					res_q.found_front <= pend_rd_q ? ram_rd_data[FRONT_W-1:0] : '0;
					res_q.found_back  <= pend_rd_q ? ram_rd_data[KEY_W-1:FRONT_W] : '0;
				end
			end
			default: begin
			end
		endcase
	end

	property p_count_matches_occ;
		@(posedge clk) disable iff (!arst_n)
		int'(count_q) == $countones(occ_q);
	endproperty
	a_count_matches_occ: assert property (p_count_matches_occ)
		else $error("key count disagrees with occupied slots");

	property p_probe_in_range;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (int'(s_q) < SLOT_COUNT) && (int'(d_q) < SLOT_COUNT);
	endproperty
	a_probe_in_range: assert property (p_probe_in_range)
		else $error("probe slot or step out of range");

	property p_insert_into_free;
		@(posedge clk) disable iff (!arst_n)
		ram_wr |-> !occ_q[free_slot_q];
	endproperty
	a_insert_into_free: assert property (p_insert_into_free)
		else $error("insert targets an occupied slot");

	property p_result_from_done;
		@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DONE);
	endproperty
	a_result_from_done: assert property (p_result_from_done)
		else $error("result word loaded outside the hand-off state");

endmodule
